// ===== design/sfa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the segment fit allocator.
// No dependencies; every other design file but sfa_ram imports this package.
package sfa_pkg;

	// operation codes
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_ALLOC  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NO_FIT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_ZERO   = 2'd3;

	// search policies; the unused code behaves as first fit
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] amount;
	} req_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] chosen_index;
		logic       split_made;
		logic [3:0] remainder_index;
		logic [4:0] segment_total;
	} rsp_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_UPDATE,
		S_SPLIT,
		S_EMIT
	} sfa_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture the request item, restart the scan
		logic scan_step;  // read one table entry, advance the scan index
		logic update;     // decide and commit the table change
		logic split;      // write the remainder size
		logic emit;       // move the result into the output register
	} sfa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic needs_scan; // incoming item is a request that must search
		logic scan_last;  // scan index is at the last live entry
	} sfa_stat_t;

endpackage

// ===== design/sfa_ram.sv =====
`timescale 1ns / 1ps
// Generic single write port RAM with one registered read port.
// No dependencies.
module sfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

// ===== design/sfa_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the segment fit allocator: size RAM, free marks, fit search,
// commit logic and output register. Depends on sfa_pkg and sfa_ram.
module sfa_datapath #(
	parameter int MAX_SEGMENTS = 16,
	parameter int SIZE_BITS    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_data,
	input  sfa_pkg::req_item_t req_item,
	input  sfa_pkg::sfa_cmd_t  cmd,
	output sfa_pkg::sfa_stat_t stat,
	output sfa_pkg::rsp_item_t rsp_item
);
	import sfa_pkg::*;

	localparam int IDX_W = $clog2(MAX_SEGMENTS);
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

	logic [1:0]              policy_q;
	logic [1:0]              op_q;
	logic [SIZE_BITS-1:0]    amt_q;
	logic [CNT_W-1:0]        count_q;
	logic [MAX_SEGMENTS-1:0] free_q;

	logic [IDX_W-1:0]        scan_idx_q;
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic                    free_s1;
	logic [SIZE_BITS-1:0]    rd_data_s1;

	logic                    found_q;
	logic [IDX_W-1:0]        pick_q;
	logic [SIZE_BITS-1:0]    best_q;
	logic [SIZE_BITS-1:0]    pick_size_q;

	logic                    split_q;
	logic [IDX_W-1:0]        rem_idx_q;
	logic [SIZE_BITS-1:0]    rest_q;
	rsp_item_t               res_q;
	rsp_item_t               rsp_q;

	logic [SIZE_BITS-1:0]    amt_in;
	logic [IDX_W-1:0]        count_idx;

	// search compare
	logic                    eligible;
	logic [SIZE_BITS-1:0]    gap;
	logic                    take;
	logic [SIZE_BITS-1:0]    new_best;

	// commit decision
	logic [SIZE_BITS-1:0]    rest;
	logic                    full;
	logic [1:0]              upd_status;
	logic [IDX_W-1:0]        upd_chosen;
	logic                    upd_split;
	logic [CNT_W-1:0]        count_next;
	logic                    upd_we;
	logic [IDX_W-1:0]        upd_addr;
	logic                    set_free;
	logic                    clr_free;
	logic                    clr_all;

	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	logic [SIZE_BITS-1:0]    ram_wdata;

	assign amt_in    = SIZE_BITS'(req_item.amount);
	assign count_idx = count_q[IDX_W-1:0];

	assign stat.needs_scan = (req_item.operation == OP_ALLOC) && (amt_in != '0)
		&& (count_q != '0);
	assign stat.scan_last  = CNT_W'(scan_idx_q) == (count_q - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIRST;
		end else if (cfg_write) begin
			policy_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req_item.operation;
			amt_q <= amt_in;
		end
	end

	// ---- scan: read address stage, then compare stage ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_step;
			if (cmd.load) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end else begin
				if (cmd.scan_step) begin
					scan_idx_q <= scan_idx_q + IDX_W'(1);
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q;
		free_s1   <= free_q[scan_idx_q];
		if (take) begin
			pick_q      <= rd_idx_s1;
			best_q      <= new_best;
			pick_size_q <= rd_data_s1;
		end
	end

	assign eligible = rd_vld_s1 && free_s1 && (rd_data_s1 >= amt_q);
	assign gap      = rd_data_s1 - amt_q;

	always_comb begin
		case (policy_q)
			POL_BEST: begin
				take     = eligible && (!found_q || gap <= best_q);
				new_best = gap;
			end
			POL_WORST: begin
				take     = eligible && (!found_q || rd_data_s1 > best_q);
				new_best = rd_data_s1;
			end
			default: begin
				take     = eligible && !found_q;
				new_best = rd_data_s1;
			end
		endcase
	end

	// ---- commit decision ----
	assign rest = pick_size_q - amt_q;
	assign full = count_q >= CNT_W'(MAX_SEGMENTS);

	always_comb begin
		upd_status = ST_OK;
		upd_chosen = '0;
		upd_split  = 1'b0;
		count_next = count_q;
		upd_we     = 1'b0;
		upd_addr   = count_idx;
		set_free   = 1'b0;
		clr_free   = 1'b0;
		clr_all    = 1'b0;
		case (op_q)
			OP_CLEAR: begin
				clr_all    = 1'b1;
				count_next = '0;
			end
			OP_APPEND: begin
				if (amt_q == '0) begin
					upd_status = ST_ZERO;
				end else if (full) begin
					upd_status = ST_FULL;
				end else begin
					upd_we     = 1'b1;
					set_free   = 1'b1;
					upd_chosen = count_idx;
					count_next = count_q + CNT_W'(1);
				end
			end
			OP_ALLOC: begin
				if (amt_q == '0) begin
					upd_status = ST_ZERO;
				end else if (!found_q) begin
					upd_status = ST_NO_FIT;
				end else if ((rest != '0) && full) begin
					upd_status = ST_FULL;
				end else begin
					upd_we     = 1'b1;
					upd_addr   = pick_q;
					clr_free   = 1'b1;
					upd_chosen = pick_q;
					if (rest != '0) begin
						upd_split  = 1'b1;
						set_free   = 1'b1;
						count_next = count_q + CNT_W'(1);
					end
				end
			end
			default: begin
				upd_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			free_q  <= '0;
			split_q <= 1'b0;
		end else if (cmd.update) begin
			count_q <= count_next;
			split_q <= upd_split;
			if (clr_all) begin
				free_q <= '0;
			end else begin
				// chosen index is always below count, so the two never collide
				if (clr_free) begin
					free_q[pick_q] <= 1'b0;
				end
				if (set_free) begin
					free_q[count_idx] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			rem_idx_q             <= count_idx;
			rest_q                <= rest;
			res_q.status          <= upd_status;
			res_q.chosen_index    <= 4'(upd_chosen);
			res_q.split_made      <= upd_split;
			res_q.remainder_index <= upd_split ? 4'(count_idx) : 4'd0;
			res_q.segment_total   <= 5'(count_next);
		end
		if (cmd.emit) begin
			rsp_q <= res_q;
		end
	end

	// one write port: chosen size during update, remainder in the next cycle
	assign ram_we    = (cmd.update && upd_we) || (cmd.split && split_q);
	assign ram_waddr = cmd.split ? rem_idx_q : upd_addr;
	assign ram_wdata = cmd.split ? rest_q : amt_q;

	sfa_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (MAX_SEGMENTS)
	) u_size_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (scan_idx_q),
		.rd_data (rd_data_s1)
	);

	assign rsp_item = rsp_q;
endmodule

// ===== design/sfa_control.sv =====
`timescale 1ns / 1ps
// Sequencer of the segment fit allocator: item handshake, scan control,
// commit and result hand-off. Depends on sfa_pkg.
module sfa_control (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	input  sfa_pkg::sfa_stat_t stat,
	output sfa_pkg::sfa_cmd_t  cmd
);
	import sfa_pkg::*;

	sfa_state_t state_q;
	sfa_state_t state_next;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		req_stall  = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load   = 1'b1;
					state_next = stat.needs_scan ? S_SCAN : S_UPDATE;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_next = S_LAST;
				end
			end
			S_LAST: begin
				state_next = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_next = S_SPLIT;
			end
			S_SPLIT: begin
				cmd.split = 1'b1;
				if (out_free) begin
					cmd.emit   = 1'b1;
					state_next = S_IDLE;
				end else begin
					state_next = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit   = 1'b1;
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
endmodule

// ===== design/segment_fit_allocator.sv =====
`timescale 1ns / 1ps
// Top level of the segment fit allocator: sequencer plus datapath.
// Depends on sfa_pkg, sfa_control, sfa_datapath (and sfa_ram below it).
//
//   channel    signals                          direction  item
//   ---------  -------------------------------  ---------  --------------------------
//   request    req_valid, req_stall, req_item   in         operation, amount
//   response   rsp_valid, rsp_stall, rsp_item   out        status, indexes, total
//   config     cfg_write, cfg_data              in         fit_policy, no read-back
//
// An allocate request with N segments in the table passes from acceptance to the
// next acceptance through one scan step per entry read from the size RAM, a step
// to finish the last compare, the commit and the remainder write. Append, clear,
// zero-size and empty-table requests skip the scan and the last compare.
// Reset clears the count and the free marks at once; the size RAM needs no
// clearing pass since only entries below the count are ever read.
// A stalled response holds in the output register; a new request is still
// taken, and its result waits for the register to drain.
module segment_fit_allocator #(
	parameter int MAX_SEGMENTS = 16,
	parameter int SIZE_BITS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// config
	input  logic               cfg_write,
	input  logic [1:0]         cfg_data,
	// request
	input  logic               req_valid,
	output logic               req_stall,
	input  sfa_pkg::req_item_t req_item,
	// response
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output sfa_pkg::rsp_item_t rsp_item
);
	import sfa_pkg::*;

	sfa_cmd_t  cmd;
	sfa_stat_t stat;

	// state machine: handshake and step sequencing
	sfa_control u_control (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// table storage, fit search, commit and output register
	sfa_datapath #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.SIZE_BITS    (SIZE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.req_item  (req_item),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_item  (rsp_item)
	);
endmodule

// ===== design/sfa_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the segment fit allocator, bound to the top level.
// Depends on sfa_pkg and segment_fit_allocator.
module sfa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input sfa_pkg::rsp_item_t rsp_item
);
	import sfa_pkg::*;

	// one item in flight: the request side closes right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while previous item still in work");

	// no result can surface the cycle after an accept
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> !$rose(rsp_valid))
		else $error("response appeared too early");

	// a refused item leaves the index fields at zero
	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_item.status != ST_OK) |->
		(rsp_item.chosen_index == 4'd0 && !rsp_item.split_made
		&& rsp_item.remainder_index == 4'd0))
		else $error("failed item carries nonzero index fields");

	// a split only on success, and it always leaves at least two segments
	a_split_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_item.split_made) |->
		(rsp_item.status == ST_OK && rsp_item.segment_total >= 5'd2))
		else $error("split reported with bad status or total");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)))
		else $error("stalled response changed");
endmodule

bind segment_fit_allocator sfa_checker u_sfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_item  (rsp_item)
);
